// File: src/dmwm_pkg.sv
// ----------------------------------------------------------------------------
// dmwm_pkg: shared types and constants of the modulation word mapper
// Register codes, mode codes, configuration and result structs.
// ----------------------------------------------------------------------------
package dmwm_pkg;

  localparam int PHASE_BITS = 14;
  localparam int PW_BITS    = 4 * PHASE_BITS;
  localparam int FREQ_BITS  = 32;
  localparam int AMP_BITS   = 10;
  localparam int MSK_BITS   = FREQ_BITS + PHASE_BITS + 1;

  localparam logic [PHASE_BITS-1:0] PH_MID    = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS-1:0] PH_MID_M1 = {1'b0, {(PHASE_BITS-1){1'b1}}};
  localparam logic [AMP_BITS-1:0]   AMP_MAX   = {AMP_BITS{1'b1}};

  typedef enum logic [3:0] {
    MODE_OFF     = 4'd0,
    MODE_CW      = 4'd1,
    MODE_FSK     = 4'd2,
    MODE_ASK     = 4'd3,
    MODE_GFSK    = 4'd4,
    MODE_MSK     = 4'd5,
    MODE_QPSK    = 4'd6,
    MODE_FOURFSK = 4'd7,
    MODE_AM      = 4'd8,
    MODE_FM      = 4'd9,
    MODE_BPSK    = 4'd10
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_FREQ_LOW  = 3'd1,
    REG_FREQ_HIGH = 3'd2,
    REG_PHASE     = 3'd3,
    REG_AMP_PRI   = 3'd4,
    REG_AMP_SEC   = 3'd5,
    REG_DEVIATION = 3'd6,
    REG_MSK_STEP  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]            mode;
    logic [63:0]           freq_lo;
    logic [63:0]           freq_hi;
    logic [PW_BITS-1:0]    phase_words;
    logic [AMP_BITS-1:0]   amp_pri;
    logic [AMP_BITS-1:0]   amp_sec;
    logic [FREQ_BITS-1:0]  deviation;
    logic [PHASE_BITS-1:0] msk_step;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0]  gauss;
    logic [PHASE_BITS-1:0] msk_acc;
  } state_t;

  typedef struct packed {
    logic                  valid_res;
    logic [FREQ_BITS-1:0]  freq_word;
    logic [AMP_BITS-1:0]   amp_word;
    logic [PHASE_BITS-1:0] phase_word;
  } res_t;

endpackage

// File: src/dmwm_map.sv
// ----------------------------------------------------------------------------
// dmwm_map: symbol to frequency/amplitude/phase word mapping
// Combinational mode mux with GFSK filter and MSK triangle scaling.
// ----------------------------------------------------------------------------
module dmwm_map (
  input  dmwm_pkg::cfg_t                     cfg,
  input  logic [1:0]                         symbol,
  input  dmwm_pkg::state_t                   st,
  output dmwm_pkg::res_t                     res,
  output dmwm_pkg::state_t                   st_nxt
);

  logic [dmwm_pkg::PHASE_BITS-1:0] ph_ent [4];
  logic [dmwm_pkg::FREQ_BITS-1:0]  fr_ent [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ph_ent[i] = cfg.phase_words[i*dmwm_pkg::PHASE_BITS +: dmwm_pkg::PHASE_BITS];
    end
  end

  assign fr_ent[0] = cfg.freq_lo[31:0];
  assign fr_ent[1] = cfg.freq_lo[63:32];
  assign fr_ent[2] = cfg.freq_hi[31:0];
  assign fr_ent[3] = cfg.freq_hi[63:32];

  // gfsk: y = (3*y + target) / 4, toward zero
  logic signed [31:0] g_cur;
  logic signed [31:0] g_tgt;
  logic signed [34:0] g_sum;
  logic signed [34:0] g_bias;
  logic signed [34:0] g_new;

  always_comb begin
    g_cur  = st.gauss;
    g_tgt  = symbol[0] ? cfg.deviation : (32'd0 - cfg.deviation);
    g_sum  = (35'(g_cur) <<< 1) + 35'(g_cur) + 35'(g_tgt);
    g_bias = g_sum + (g_sum[34] ? 35'sd3 : 35'sd0);
    g_new  = g_bias >>> 2;
  end

  // msk: deviation * triangle(phase) / PH_MID, toward zero
  logic [dmwm_pkg::PHASE_BITS-1:0]        m_acc;
  logic [dmwm_pkg::PHASE_BITS-1:0]        m_tri;
  logic signed [dmwm_pkg::PHASE_BITS:0]   m_tri_s;
  logic signed [31:0]                     m_dev;
  logic signed [dmwm_pkg::MSK_BITS-1:0]   m_prod;
  logic signed [dmwm_pkg::MSK_BITS-1:0]   m_bias;
  logic signed [dmwm_pkg::MSK_BITS-1:0]   m_q;

  always_comb begin
    m_acc   = st.msk_acc + cfg.msk_step;
    m_tri   = (m_acc < dmwm_pkg::PH_MID) ? (dmwm_pkg::PH_MID - m_acc)
                                         : (m_acc - dmwm_pkg::PH_MID);
    m_tri_s = signed'({1'b0, m_tri});
    m_dev   = cfg.deviation;
    m_prod  = dmwm_pkg::MSK_BITS'(m_dev) * dmwm_pkg::MSK_BITS'(m_tri_s);
    m_bias  = m_prod + (m_prod[dmwm_pkg::MSK_BITS-1]
                        ? dmwm_pkg::MSK_BITS'(signed'({1'b0, dmwm_pkg::PH_MID_M1}))
                        : dmwm_pkg::MSK_BITS'(0));
    m_q     = m_bias >>> (dmwm_pkg::PHASE_BITS - 1);
  end

  // am: center +/- delta, clamped
  logic [11:0] a_sum;
  logic [dmwm_pkg::AMP_BITS-1:0] a_clip;

  always_comb begin
    a_sum = symbol[0] ? ({2'b00, cfg.amp_pri} + {2'b00, cfg.amp_sec})
                      : ({2'b00, cfg.amp_pri} - {2'b00, cfg.amp_sec});
    if (a_sum[11]) begin
      a_clip = '0;
    end else if (a_sum[10]) begin
      a_clip = dmwm_pkg::AMP_MAX;
    end else begin
      a_clip = a_sum[9:0];
    end
  end

  always_comb begin
    res.valid_res  = 1'b1;
    res.freq_word  = '0;
    res.amp_word   = cfg.amp_pri;
    res.phase_word = '0;
    st_nxt         = st;
    unique case (cfg.mode)
      dmwm_pkg::MODE_CW: begin
        res.freq_word = fr_ent[0];
      end
      dmwm_pkg::MODE_FSK: begin
        res.freq_word = fr_ent[{1'b0, symbol[0]}];
      end
      dmwm_pkg::MODE_ASK: begin
        res.freq_word = fr_ent[0];
        res.amp_word  = symbol[0] ? cfg.amp_pri : cfg.amp_sec;
      end
      dmwm_pkg::MODE_GFSK: begin
        st_nxt.gauss  = g_new[31:0];
        res.freq_word = fr_ent[0] + g_new[31:0];
      end
      dmwm_pkg::MODE_MSK: begin
        st_nxt.msk_acc = m_acc;
        res.freq_word  = fr_ent[0] + m_q[31:0];
      end
      dmwm_pkg::MODE_QPSK: begin
        res.freq_word  = fr_ent[0];
        res.phase_word = ph_ent[symbol];
      end
      dmwm_pkg::MODE_FOURFSK: begin
        res.freq_word = fr_ent[symbol];
      end
      dmwm_pkg::MODE_AM: begin
        res.freq_word = fr_ent[0];
        res.amp_word  = a_clip;
      end
      dmwm_pkg::MODE_FM: begin
        res.freq_word = symbol[0] ? (fr_ent[0] + cfg.deviation)
                                  : (fr_ent[0] - cfg.deviation);
      end
      dmwm_pkg::MODE_BPSK: begin
        res.freq_word  = fr_ent[0];
        res.phase_word = ph_ent[{1'b0, symbol[0]}];
      end
      default: begin
        res.valid_res = 1'b0;
        res.amp_word  = '0;
      end
    endcase
  end

endmodule

// File: src/dds_modulation_word_mapper.sv
// ----------------------------------------------------------------------------
// dds_modulation_word_mapper: per-channel DDS modulation word mapper
// Maps each 2-bit symbol to frequency, amplitude and phase words.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------
//  input   | in_symbol                               | in_valid / in_stall
//  result  | out_valid_res, out_freq_word,           | out_valid / out_stall
//          | out_amp_word, out_phase_word            |
//  config  | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
//  One word per cycle sustained while out_stall is low; each word passes the
//  input register, then mapping logic into the result register.
//  The MSK multiply-add and GFSK filter sit between those two registers.
//  A stalled result holds; the input register keeps taking words while the
//  result register is free or being drained.
//  Reset clears the valid flags, configuration and filter/accumulator state;
//  cfg_ready rises the cycle after.
// ----------------------------------------------------------------------------
module dds_modulation_word_mapper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_symbol,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_valid_res,
  output logic [dmwm_pkg::FREQ_BITS-1:0]      out_freq_word,
  output logic [dmwm_pkg::AMP_BITS-1:0]       out_amp_word,
  output logic [dmwm_pkg::PHASE_BITS-1:0]     out_phase_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [63:0]                         cfg_data
);

  dmwm_pkg::cfg_t   cfg_r;
  dmwm_pkg::state_t st_r;
  dmwm_pkg::state_t st_nxt;
  dmwm_pkg::res_t   res_nxt;
  dmwm_pkg::res_t   res_r;

  logic       cfg_ready_r;
  logic       s1_valid_r;
  logic [1:0] s1_sym_r;
  logic       out_valid_r;
  logic       out_take;
  logic       s1_go;
  logic       in_acc;

  assign out_take = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_take;
  assign in_stall = s1_valid_r && !out_take;
  assign in_acc   = in_valid && !in_stall;

  dmwm_map u_map (
    .cfg    (cfg_r),
    .symbol (s1_sym_r),
    .st     (st_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ready_r <= 1'b0;
      cfg_r       <= '0;
    end else begin
      cfg_ready_r <= 1'b1;
      if (cfg_valid && cfg_ready_r) begin
        unique case (cfg_index)
          dmwm_pkg::REG_MODE:      cfg_r.mode        <= cfg_data[3:0];
          dmwm_pkg::REG_FREQ_LOW:  cfg_r.freq_lo     <= cfg_data;
          dmwm_pkg::REG_FREQ_HIGH: cfg_r.freq_hi     <= cfg_data;
          dmwm_pkg::REG_PHASE:     cfg_r.phase_words <= cfg_data[dmwm_pkg::PW_BITS-1:0];
          dmwm_pkg::REG_AMP_PRI:   cfg_r.amp_pri     <= cfg_data[dmwm_pkg::AMP_BITS-1:0];
          dmwm_pkg::REG_AMP_SEC:   cfg_r.amp_sec     <= cfg_data[dmwm_pkg::AMP_BITS-1:0];
          dmwm_pkg::REG_DEVIATION: cfg_r.deviation   <= cfg_data[dmwm_pkg::FREQ_BITS-1:0];
          dmwm_pkg::REG_MSK_STEP:  cfg_r.msk_step    <= cfg_data[dmwm_pkg::PHASE_BITS-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_go) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r <= in_symbol;
    end
    if (s1_go) begin
      res_r <= res_nxt;
    end
  end

  assign cfg_ready      = cfg_ready_r;
  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_r.valid_res;
  assign out_freq_word  = res_r.freq_word;
  assign out_amp_word   = res_r.amp_word;
  assign out_phase_word = res_r.phase_word;

endmodule

// File: src/dmwm_checker.sv
// ----------------------------------------------------------------------------
// dmwm_checker: port-level checks of the modulation word mapper
// Bound to the top level; watches handshakes and result words.
// ----------------------------------------------------------------------------
module dmwm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_valid_res,
  input logic [dmwm_pkg::FREQ_BITS-1:0]      out_freq_word,
  input logic [dmwm_pkg::AMP_BITS-1:0]       out_amp_word,
  input logic [dmwm_pkg::PHASE_BITS-1:0]     out_phase_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_freq_word) && $stable(out_amp_word)
                               && $stable(out_phase_word) && $stable(out_valid_res))
    else $error("stalled result word changed");

  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted word did not reach the result register");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_freq_word == '0 && out_amp_word == '0
                                    && out_phase_word == '0)
    else $error("off-mode result carries nonzero words");

endmodule

bind dds_modulation_word_mapper dmwm_checker u_dmwm_checker (.*);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for dds_modulation_word_mapper
// Maps symbol words through every modulation mode and checks each result word
// against a local mapping model with its own filter and MSK accumulator.
// Directed corners first (clamps, wraps, most negative deviation, unknown
// mode), then random register settings with random idling on both sides and
// one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [3:0] MODE_UNKNOWN = 4'd15;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_symbol = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_valid_res;
  logic [dmwm_pkg::FREQ_BITS-1:0]  out_freq_word;
  logic [dmwm_pkg::AMP_BITS-1:0]   out_amp_word;
  logic [dmwm_pkg::PHASE_BITS-1:0] out_phase_word;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [2:0]                      cfg_index = dmwm_pkg::REG_MODE;
  logic [63:0]                     cfg_data = '0;

  dds_modulation_word_mapper i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_freq_word  (out_freq_word),
    .out_amp_word   (out_amp_word),
    .out_phase_word (out_phase_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  dmwm_pkg::cfg_t                  shadow_cfg = '0;
  int                              gauss_val = 0;
  logic [dmwm_pkg::PHASE_BITS-1:0] msk_acc = '0;

  logic [1:0]     symbol_q[$];
  dmwm_pkg::res_t expected_q[$];

  int   errors = 0;
  int   words_in = 0;
  int   words_checked = 0;
  int   words_queued = 0;
  int   settings = 0;
  bit   quiet = 1'b0;
  logic hold_kick = 1'b0;
  int   hold_left = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic dmwm_pkg::res_t map_symbol(input logic [1:0] sym);
    dmwm_pkg::res_t                  r;
    logic                            bit0;
    logic [31:0]                     center;
    logic [31:0]                     target;
    logic [127:0]                    freq_all;
    logic [dmwm_pkg::PHASE_BITS-1:0] tri_w;
    longint                          acc;
    longint                          prod;
    int                              amp;
    bit0 = sym[0];
    center = shadow_cfg.freq_lo[31:0];
    freq_all = {shadow_cfg.freq_hi, shadow_cfg.freq_lo};
    r.valid_res = 1'b1;
    r.freq_word = '0;
    r.amp_word = shadow_cfg.amp_pri;
    r.phase_word = '0;
    case (shadow_cfg.mode)
      dmwm_pkg::MODE_CW: r.freq_word = center;
      dmwm_pkg::MODE_FSK: r.freq_word = bit0 ? shadow_cfg.freq_lo[63:32] : center;
      dmwm_pkg::MODE_ASK: begin
        r.freq_word = center;
        r.amp_word = bit0 ? shadow_cfg.amp_pri : shadow_cfg.amp_sec;
      end
      dmwm_pkg::MODE_GFSK: begin
        target = bit0 ? shadow_cfg.deviation : -shadow_cfg.deviation;
        acc = longint'(gauss_val) * 3 + longint'(signed'(target));
        gauss_val = int'(acc / 4);
        r.freq_word = center + gauss_val;
      end
      dmwm_pkg::MODE_MSK: begin
        msk_acc = msk_acc + shadow_cfg.msk_step;
        tri_w = (msk_acc < dmwm_pkg::PH_MID) ? dmwm_pkg::PH_MID - msk_acc
                                             : msk_acc - dmwm_pkg::PH_MID;
        prod = longint'(signed'(shadow_cfg.deviation)) * longint'(tri_w)
               / longint'(dmwm_pkg::PH_MID);
        r.freq_word = center + prod[31:0];
      end
      dmwm_pkg::MODE_QPSK: begin
        r.freq_word = center;
        r.phase_word = shadow_cfg.phase_words[sym*dmwm_pkg::PHASE_BITS +:
                                              dmwm_pkg::PHASE_BITS];
      end
      dmwm_pkg::MODE_FOURFSK: r.freq_word = freq_all[sym*32 +: 32];
      dmwm_pkg::MODE_AM: begin
        amp = bit0 ? int'(shadow_cfg.amp_pri) + int'(shadow_cfg.amp_sec)
                   : int'(shadow_cfg.amp_pri) - int'(shadow_cfg.amp_sec);
        if (amp < 0) amp = 0;
        if (amp > int'(dmwm_pkg::AMP_MAX)) amp = int'(dmwm_pkg::AMP_MAX);
        r.freq_word = center;
        r.amp_word = amp[dmwm_pkg::AMP_BITS-1:0];
      end
      dmwm_pkg::MODE_FM: r.freq_word = bit0 ? center + shadow_cfg.deviation
                                            : center - shadow_cfg.deviation;
      dmwm_pkg::MODE_BPSK: begin
        r.freq_word = center;
        r.phase_word = shadow_cfg.phase_words[bit0*dmwm_pkg::PHASE_BITS +:
                                              dmwm_pkg::PHASE_BITS];
      end
      default: begin
        r.valid_res = 1'b0;
        r.amp_word = '0;
      end
    endcase
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("tb_top: mismatch: %s", msg);
  endtask

  // symbol driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(map_symbol(in_symbol));
        words_in++;
      end
      if (in_valid && in_stall) begin
      end else if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        tx_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (symbol_q.size() != 0) begin
        in_valid <= 1'b1;
        in_symbol <= symbol_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long result hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= 250;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    dmwm_pkg::res_t seen;
    dmwm_pkg::res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_valid_res, out_freq_word, out_amp_word, out_phase_word};
        if (expected_q.size() == 0) begin
          note_error($sformatf("unexpected word valid_res=%0b freq=%h amp=%h phase=%h",
                               seen.valid_res, seen.freq_word, seen.amp_word,
                               seen.phase_word));
        end else begin
          want = expected_q.pop_front();
          words_checked++;
          if (seen.valid_res !== want.valid_res || seen.freq_word !== want.freq_word ||
              seen.amp_word !== want.amp_word || seen.phase_word !== want.phase_word)
            note_error($sformatf(
              "word %0d exp valid_res=%0b freq=%h amp=%h phase=%h got %0b %h %h %h",
              words_checked, want.valid_res, want.freq_word, want.amp_word,
              want.phase_word, seen.valid_res, seen.freq_word, seen.amp_word,
              seen.phase_word));
        end
      end
      if (hold_left != 0 || hold_kick) begin
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic settle();
    do @(posedge clk);
    while (symbol_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input dmwm_pkg::reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      dmwm_pkg::REG_MODE:      shadow_cfg.mode = data[3:0];
      dmwm_pkg::REG_FREQ_LOW:  shadow_cfg.freq_lo = data;
      dmwm_pkg::REG_FREQ_HIGH: shadow_cfg.freq_hi = data;
      dmwm_pkg::REG_PHASE:     shadow_cfg.phase_words = data[dmwm_pkg::PW_BITS-1:0];
      dmwm_pkg::REG_AMP_PRI:   shadow_cfg.amp_pri = data[dmwm_pkg::AMP_BITS-1:0];
      dmwm_pkg::REG_AMP_SEC:   shadow_cfg.amp_sec = data[dmwm_pkg::AMP_BITS-1:0];
      dmwm_pkg::REG_DEVIATION: shadow_cfg.deviation = data[dmwm_pkg::FREQ_BITS-1:0];
      dmwm_pkg::REG_MSK_STEP:  shadow_cfg.msk_step = data[dmwm_pkg::PHASE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_reg(input dmwm_pkg::reg_idx_t idx, input logic [63:0] data);
    settle();
    cfg_write(idx, data);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic write_all(input logic [63:0] m, input logic [63:0] flo,
                           input logic [63:0] fhi, input logic [63:0] ph,
                           input logic [63:0] pri, input logic [63:0] sec,
                           input logic [63:0] dev, input logic [63:0] step);
    settle();
    cfg_write(dmwm_pkg::REG_MODE, m);
    cfg_write(dmwm_pkg::REG_FREQ_LOW, flo);
    cfg_write(dmwm_pkg::REG_FREQ_HIGH, fhi);
    cfg_write(dmwm_pkg::REG_PHASE, ph);
    cfg_write(dmwm_pkg::REG_AMP_PRI, pri);
    cfg_write(dmwm_pkg::REG_AMP_SEC, sec);
    cfg_write(dmwm_pkg::REG_DEVIATION, dev);
    cfg_write(dmwm_pkg::REG_MSK_STEP, step);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // n symbols packed low first, two bits each
  task automatic feed(input int n, input logic [7:0] syms);
    for (int i = 0; i < n; i++) symbol_q.push_back(syms[2*i +: 2]);
    words_queued += n;
  endtask

  function automatic logic [63:0] rand_field(input int w);
    logic [63:0] v;
    logic [63:0] ones;
    v = {$urandom, $urandom};
    ones = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    case ($urandom_range(0, 5))
      0: v = v & ~ones;
      1: v = v | ones;
      2: v = (v & ~ones) | (64'd1 << (w - 1));
      3: v = (v | ones) & ~(64'd1 << (w - 1));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] m;
    int          n;
    bit          pressed;
    pressed = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: off
    feed(2, 8'b0000_1100);

    write_all(dmwm_pkg::MODE_CW, {32'hFFFF_FFFF, 32'hFFFF_FFF0},
              {32'h0000_0000, 32'h1234_5678},
              {14'h3FFF, 14'h0000, 14'h2000, 14'h1FFF}, 64'h3FF, 64'h3FF,
              64'h8000_0000, 64'h3FFF);
    feed(1, 8'b11);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_FSK);     feed(2, 8'b0100);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_ASK);     feed(2, 8'b0100);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_GFSK);    feed(3, 8'b00_01_01);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_MSK);     feed(2, 8'b1100);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_QPSK);    feed(4, 8'b11_10_01_00);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_FOURFSK); feed(4, 8'b11_10_01_00);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_AM);      feed(2, 8'b0100);
    set_reg(dmwm_pkg::REG_AMP_PRI, 64'h5);               feed(1, 8'b10);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_FM);      feed(2, 8'b0100);
    set_reg(dmwm_pkg::REG_DEVIATION, 64'h7FFF_FFFF);     feed(2, 8'b1011);
    set_reg(dmwm_pkg::REG_MODE, dmwm_pkg::MODE_BPSK);    feed(2, 8'b1001);
    set_reg(dmwm_pkg::REG_MODE, MODE_UNKNOWN);           feed(1, 8'b11);

    while (words_queued < 390) begin
      n = $urandom_range(8, 32);
      m = {$urandom, $urandom};
      m[3:0] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 10));
      write_all(m, rand_field(32), rand_field(32), rand_field(56), rand_field(10),
                rand_field(10), rand_field(32), rand_field(14));
      quiet = (words_queued > 340) || ($urandom_range(0, 3) == 0);
      if (!pressed && words_queued > 150) begin
        pressed = 1'b1;
        quiet = 1'b1;
        for (int i = 0; i < 48; i++) symbol_q.push_back($urandom_range(0, 3));
        words_queued += 48;
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end else begin
        for (int i = 0; i < n; i++) symbol_q.push_back($urandom_range(0, 3));
        words_queued += n;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    errors += expected_q.size();
    $display("tb_top: %0d symbol words mapped under %0d register settings, %0d checked",
             words_in, settings, words_checked);
    $display("tb_top: all modes, unknown mode, clamps and wraps, long output hold-off");
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: timeout");
    $display("tb_top: errors");
    $finish;
  end

endmodule

// File: files.f
src/dmwm_pkg.sv
src/dmwm_map.sv
src/dds_modulation_word_mapper.sv
src/dmwm_checker.sv
dv/tb_top.sv
